// File: rtl/skvt_pkg.sv
// Shared constants, codes, types and a helper function of the sorted key/datum table.
package skvt_pkg;

    localparam int OP_BITS        = 3;
    localparam int KEY_BITS       = 32;
    localparam int WORD_BITS      = 64;
    localparam int STATUS_BITS    = 2;
    localparam int COUNT_OUT_BITS = 7;

    localparam int DEF_CAPACITY   = 64;
    localparam int DEF_DATUM_BITS = 64;

    localparam int TREE_RADIX_LOG = 3;

    localparam logic [OP_BITS-1:0] OP_INSERT = 3'd0;
    localparam logic [OP_BITS-1:0] OP_REMOVE = 3'd1;
    localparam logic [OP_BITS-1:0] OP_FIND   = 3'd2;
    localparam logic [OP_BITS-1:0] OP_FIRST  = 3'd3;
    localparam logic [OP_BITS-1:0] OP_STEP   = 3'd4;
    localparam logic [OP_BITS-1:0] OP_CLEAR  = 3'd5;

    localparam logic [STATUS_BITS-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND  = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL       = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_CURSOR_BAD = 2'd3;

    // Broadcast from the sequencer to every cell
    typedef struct packed {
        logic                exec;
        logic [OP_BITS-1:0]  op;
        logic [KEY_BITS-1:0] key;
        logic                found;
        logic                full;
    } cell_ctrl_t;

    // Register levels of the OR tree needed to cover n lanes
    function automatic int tree_levels(input int n);
        int levels;
        int span;
        levels = 0;
        span   = 1;
        while (span < n)
        begin
            span   = span << TREE_RADIX_LOG;
            levels = levels + 1;
        end
        return levels;
    endfunction

endpackage

// File: rtl/skvt_if.sv
// Request and response channel interfaces of the sorted key/datum table.
interface skvt_req_if import skvt_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [OP_BITS-1:0]         operation;
    logic signed [KEY_BITS-1:0] key;
    logic [WORD_BITS-1:0]       datum;

    modport source (output valid, output operation, output key, output datum, input ready);
    modport sink   (input valid, input operation, input key, input datum, output ready);
endinterface

interface skvt_rsp_if import skvt_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic [STATUS_BITS-1:0]      status;
    logic                        cursor_valid;
    logic signed [KEY_BITS-1:0]  cur_key;
    logic [WORD_BITS-1:0]        cur_datum;
    logic [COUNT_OUT_BITS-1:0]   entry_count;

    modport source (output valid, output status, output cursor_valid, output cur_key,
                    output cur_datum, output entry_count, input ready);
    modport sink   (input valid, input status, input cursor_valid, input cur_key,
                    input cur_datum, input entry_count, output ready);
endinterface

// File: rtl/sorted_key_value_table_core.sv
// Top level of the sorted key/datum table: sequencer, cell row and readout tree.
//
// Requests arrive on req (operation, key, datum); each gives one response on rsp
// (status, cursor_valid, cur_key, cur_datum, entry_count). Entries sit in a
// row of CAPACITY cells kept in ascending signed key order; every cell compares
// itself against the key, and the row shifts as a whole for insert or remove.
// A registered radix-8 OR tree of L = ceil(log8(CAPACITY)) levels first
// reports whether the key is present, then reads out the cell holding the
// cursor mark. A request passes through the search, shift and readout states
// before its response is offered; the next request is taken once the current
// one has reached the output register, so requests are never overlapped.
// Results wait in an output register and req is ready again meanwhile; a stalled
// receiver holds back the hand-over of the following result and any later request.
// Reset empties the table, drops the cursor and clears any pending response; the
// cell contents are not cleared and need no sweep.
module sorted_key_value_table_core import skvt_pkg::*; #(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int DATUM_BITS = DEF_DATUM_BITS
) (
    input logic         clk,
    input logic         rst_n,
    skvt_req_if.sink    req,
    skvt_rsp_if.source  rsp
);

    localparam int CNT_BITS   = $clog2(CAPACITY + 1);
    localparam int LANE_BITS  = 1 + KEY_BITS + DATUM_BITS;
    localparam int LEVELS     = tree_levels(CAPACITY);
    localparam int WAIT_BITS  = $clog2(LEVELS + 1);
    localparam int STATE_BITS = 3;

    localparam logic [STATE_BITS-1:0] S_IDLE = 3'd0;
    localparam logic [STATE_BITS-1:0] S_SRCH = 3'd1;
    localparam logic [STATE_BITS-1:0] S_EXEC = 3'd2;
    localparam logic [STATE_BITS-1:0] S_READ = 3'd3;
    localparam logic [STATE_BITS-1:0] S_DONE = 3'd4;

    logic [STATE_BITS-1:0]     state_reg;
    logic [STATE_BITS-1:0]     state_next;
    logic [WAIT_BITS-1:0]      wait_reg;
    logic [WAIT_BITS-1:0]      wait_next;
    logic [OP_BITS-1:0]        op_reg;
    logic [KEY_BITS-1:0]       key_reg;
    logic [DATUM_BITS-1:0]     datum_reg;
    logic [CNT_BITS-1:0]       count_reg;
    logic [CNT_BITS-1:0]       count_next;
    logic                      live_reg;
    logic [STATUS_BITS-1:0]    res_status_reg;
    logic [STATUS_BITS-1:0]    res_status_next;

    logic                      rsp_valid_reg;
    logic [STATUS_BITS-1:0]    status_reg;
    logic                      cvalid_reg;
    logic [KEY_BITS-1:0]       ckey_reg;
    logic [WORD_BITS-1:0]      cdatum_reg;
    logic [COUNT_OUT_BITS-1:0] ecount_reg;

    logic                      accept;
    logic                      load_out;
    logic                      found;
    logic                      full;
    cell_ctrl_t                cell_ctrl;
    logic [LANE_BITS-1:0]      tree_out;
    logic [LANE_BITS-1:0]      lanes [CAPACITY];

    logic [KEY_BITS-1:0]       cell_key   [CAPACITY];
    logic [DATUM_BITS-1:0]     cell_datum [CAPACITY];
    logic                      cell_flag  [CAPACITY];
    logic                      cell_less  [CAPACITY];
    logic                      cell_hit   [CAPACITY];
    logic                      cell_occ   [CAPACITY];
    logic [KEY_BITS-1:0]       left_key    [CAPACITY];
    logic [DATUM_BITS-1:0]     left_datum  [CAPACITY];
    logic                      left_flag   [CAPACITY];
    logic                      left_less   [CAPACITY];
    logic [KEY_BITS-1:0]       right_key   [CAPACITY];
    logic [DATUM_BITS-1:0]     right_datum [CAPACITY];
    logic                      right_flag  [CAPACITY];
    logic [CAPACITY-1:0]       flag_vec;
    logic [CAPACITY-1:0]       occ_vec;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign load_out  = (state_reg == S_DONE) && (!rsp_valid_reg || rsp.ready);
    assign found     = tree_out[LANE_BITS-1];
    assign full      = (count_reg == CNT_BITS'(CAPACITY));

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        wait_next  = wait_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                wait_next = '0;
                if (req.valid)
                begin
                    state_next = S_SRCH;
                end
            end
            S_SRCH:
            begin
                if (wait_reg == WAIT_BITS'(LEVELS - 1))
                begin
                    state_next = S_EXEC;
                    wait_next  = '0;
                end
                else
                begin
                    wait_next = wait_reg + 1'b1;
                end
            end
            S_EXEC: state_next = S_READ;
            S_READ:
            begin
                if (wait_reg == WAIT_BITS'(LEVELS - 1))
                begin
                    state_next = S_DONE;
                    wait_next  = '0;
                end
                else
                begin
                    wait_next = wait_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // count and status, settled in the shift cycle
    always_comb
    begin
        count_next      = count_reg;
        res_status_next = res_status_reg;
        if (state_reg == S_EXEC)
        begin
            res_status_next = ST_OK;
            unique case (op_reg)
                OP_INSERT:
                begin
                    if (!found)
                    begin
                        if (full)
                        begin
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                end
                OP_REMOVE:
                begin
                    if (found)
                    begin
                        count_next = count_reg - 1'b1;
                    end
                    else
                    begin
                        res_status_next = ST_NOT_FOUND;
                    end
                end
                OP_FIND:
                begin
                    if (!found)
                    begin
                        res_status_next = ST_NOT_FOUND;
                    end
                end
                OP_STEP:
                begin
                    if (!live_reg)
                    begin
                        res_status_next = ST_CURSOR_BAD;
                    end
                end
                OP_CLEAR: count_next = '0;
                default:  res_status_next = ST_OK;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wait_reg      <= '0;
            count_reg     <= '0;
            live_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wait_reg  <= wait_next;
            count_reg <= count_next;
            if (load_out)
            begin
                live_reg      <= tree_out[LANE_BITS-1];
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_status_reg <= res_status_next;
        if (accept)
        begin
            op_reg    <= req.operation;
            key_reg   <= req.key;
            datum_reg <= req.datum[DATUM_BITS-1:0];
        end
        if (load_out)
        begin
            status_reg <= res_status_reg;
            cvalid_reg <= tree_out[LANE_BITS-1];
            ckey_reg   <= tree_out[LANE_BITS-2 -: KEY_BITS];
            cdatum_reg <= WORD_BITS'(tree_out[DATUM_BITS-1:0]);
            ecount_reg <= COUNT_OUT_BITS'(count_reg);
        end
    end

    assign cell_ctrl.exec  = (state_reg == S_EXEC);
    assign cell_ctrl.op    = op_reg;
    assign cell_ctrl.key   = key_reg;
    assign cell_ctrl.found = found;
    assign cell_ctrl.full  = full;

    // cell row
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            assign left_key[i]   = '0;
            assign left_datum[i] = '0;
            assign left_flag[i]  = 1'b0;
            assign left_less[i]  = 1'b1;
        end
        else
        begin : g_left
            assign left_key[i]   = cell_key[i-1];
            assign left_datum[i] = cell_datum[i-1];
            assign left_flag[i]  = cell_flag[i-1];
            assign left_less[i]  = cell_less[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_key[i]   = '0;
            assign right_datum[i] = '0;
            assign right_flag[i]  = 1'b0;
        end
        else
        begin : g_right
            assign right_key[i]   = cell_key[i+1];
            assign right_datum[i] = cell_datum[i+1];
            assign right_flag[i]  = cell_flag[i+1];
        end

        skvt_cell #(
            .INDEX      (i),
            .DATUM_BITS (DATUM_BITS),
            .CNT_BITS   (CNT_BITS)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (cell_ctrl),
            .count       (count_reg),
            .req_datum   (datum_reg),
            .left_key    (left_key[i]),
            .left_datum  (left_datum[i]),
            .left_flag   (left_flag[i]),
            .left_less   (left_less[i]),
            .right_key   (right_key[i]),
            .right_datum (right_datum[i]),
            .right_flag  (right_flag[i]),
            .key         (cell_key[i]),
            .datum       (cell_datum[i]),
            .flag        (cell_flag[i]),
            .less        (cell_less[i]),
            .hit         (cell_hit[i]),
            .occupied    (cell_occ[i])
        );

        // search pass carries the match bit, readout pass only the marked cell
        assign lanes[i] = (state_reg == S_SRCH)
                        ? {cell_hit[i], (LANE_BITS - 1)'(0)}
                        : (cell_flag[i] ? {1'b1, cell_key[i], cell_datum[i]} : '0);

        assign flag_vec[i] = cell_flag[i];
        assign occ_vec[i]  = cell_occ[i];
    end

    skvt_or_tree #(
        .LANES     (CAPACITY),
        .LANE_BITS (LANE_BITS)
    ) u_tree (
        .clk    (clk),
        .lanes  (lanes),
        .result (tree_out)
    );

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = status_reg;
    assign rsp.cursor_valid = cvalid_reg;
    assign rsp.cur_key      = ckey_reg;
    assign rsp.cur_datum    = cdatum_reg;
    assign rsp.entry_count  = ecount_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(CAPACITY))
        else $error("entry count beyond capacity");

    a_one_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(flag_vec))
        else $error("more than one cursor mark in the row");

    a_cursor_held: assert property (@(posedge clk) disable iff (!rst_n)
        (flag_vec & ~occ_vec) == '0)
        else $error("cursor mark on an empty cell");

    a_count_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_EXEC) |=> $stable(count_reg))
        else $error("entry count changed outside the shift cycle");

    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("response raised outside the hand-over state");
`endif

endmodule

// File: rtl/skvt_cell.sv
// One table cell: holds a key, a datum and the cursor mark, shifts with its neighbours.
module skvt_cell import skvt_pkg::*; #(
    parameter int INDEX      = 0,
    parameter int DATUM_BITS = DEF_DATUM_BITS,
    parameter int CNT_BITS   = 7
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cell_ctrl_t            ctrl,
    input  logic [CNT_BITS-1:0]   count,
    input  logic [DATUM_BITS-1:0] req_datum,
    input  logic [KEY_BITS-1:0]   left_key,
    input  logic [DATUM_BITS-1:0] left_datum,
    input  logic                  left_flag,
    input  logic                  left_less,
    input  logic [KEY_BITS-1:0]   right_key,
    input  logic [DATUM_BITS-1:0] right_datum,
    input  logic                  right_flag,
    output logic [KEY_BITS-1:0]   key,
    output logic [DATUM_BITS-1:0] datum,
    output logic                  flag,
    output logic                  less,
    output logic                  hit,
    output logic                  occupied
);

    localparam logic IS_HEAD = (INDEX == 0);

    logic [KEY_BITS-1:0]   key_reg;
    logic [KEY_BITS-1:0]   key_next;
    logic [DATUM_BITS-1:0] datum_reg;
    logic [DATUM_BITS-1:0] datum_next;
    logic                  flag_reg;
    logic                  flag_next;
    logic                  boundary;

    assign occupied = CNT_BITS'(INDEX) < count;
    assign less     = occupied && ($signed(key_reg) < $signed(ctrl.key));
    assign hit      = occupied && (key_reg == ctrl.key);
    // first cell not below the request key: where a new entry lands
    assign boundary = !less && left_less;

    always_comb
    begin
        key_next   = key_reg;
        datum_next = datum_reg;
        flag_next  = flag_reg;
        if (ctrl.exec)
        begin
            unique case (ctrl.op)
                OP_INSERT:
                begin
                    flag_next = 1'b0;
                    if (ctrl.found)
                    begin
                        if (hit)
                        begin
                            datum_next = req_datum;
                        end
                    end
                    else if (!ctrl.full && !less)
                    begin
                        if (boundary)
                        begin
                            key_next   = ctrl.key;
                            datum_next = req_datum;
                        end
                        else
                        begin
                            key_next   = left_key;
                            datum_next = left_datum;
                        end
                    end
                end
                OP_REMOVE:
                begin
                    if (ctrl.found && !less)
                    begin
                        key_next   = right_key;
                        datum_next = right_datum;
                        flag_next  = right_flag;
                    end
                end
                OP_FIND:  flag_next = hit;
                OP_FIRST: flag_next = IS_HEAD && occupied;
                OP_STEP:  flag_next = left_flag && occupied;
                OP_CLEAR: flag_next = 1'b0;
                default:  flag_next = flag_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        datum_reg <= datum_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg <= 1'b0;
        end
        else
        begin
            flag_reg <= flag_next;
        end
    end

    assign key   = key_reg;
    assign datum = datum_reg;
    assign flag  = flag_reg;

endmodule

// File: rtl/skvt_or_tree.sv
// Registered radix-8 OR reduction across all cell lanes.
module skvt_or_tree import skvt_pkg::*; #(
    parameter int LANES     = DEF_CAPACITY,
    parameter int LANE_BITS = 1 + KEY_BITS + DEF_DATUM_BITS
) (
    input  logic                 clk,
    input  logic [LANE_BITS-1:0] lanes [LANES],
    output logic [LANE_BITS-1:0] result
);

    localparam int LEVELS = tree_levels(LANES);
    localparam int RADIX  = 1 << TREE_RADIX_LOG;

    logic [LANE_BITS-1:0] lvl_reg  [LEVELS][LANES];
    logic [LANE_BITS-1:0] lvl_next [LEVELS][LANES];

    for (genvar l = 0; l < LEVELS; l++)
    begin : g_lvl
        if (l == 0)
        begin : g_leaf
            always_comb
            begin
                for (int j = 0; j < LANES; j++)
                begin
                    lvl_next[l][j] = '0;
                    for (int k = 0; k < RADIX; k++)
                    begin
                        if (j * RADIX + k < LANES)
                        begin
                            lvl_next[l][j] = lvl_next[l][j] | lanes[j * RADIX + k];
                        end
                    end
                end
            end
        end
        else
        begin : g_node
            always_comb
            begin
                for (int j = 0; j < LANES; j++)
                begin
                    lvl_next[l][j] = '0;
                    for (int k = 0; k < RADIX; k++)
                    begin
                        if (j * RADIX + k < LANES)
                        begin
                            lvl_next[l][j] = lvl_next[l][j] | lvl_reg[l-1][j * RADIX + k];
                        end
                    end
                end
            end
        end

        always_ff @(posedge clk)
        begin
            lvl_reg[l] <= lvl_next[l];
        end
    end

    assign result = lvl_reg[LEVELS-1][0];

endmodule

// File: verif/skvt_table_checker.sv
// Checker for the sorted key/datum table: watches both channels, predicts and compares.
`timescale 1ns / 100ps
module skvt_table_checker import skvt_pkg::*; #(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int DATUM_BITS = DEF_DATUM_BITS
) (
    input  logic clk,
    input  logic rst_n,
    skvt_req_if  req,
    skvt_rsp_if  rsp,
    output int   fail_count,
    output int   pending
);

    localparam logic [WORD_BITS-1:0] DATUM_MASK = {WORD_BITS{1'b1}} >> (WORD_BITS - DATUM_BITS);

    typedef struct packed {
        logic [STATUS_BITS-1:0]     status;
        logic                       cursor_valid;
        logic signed [KEY_BITS-1:0] cur_key;
        logic [WORD_BITS-1:0]       cur_datum;
        logic [COUNT_OUT_BITS-1:0]  entry_count;
    } table_response_t;

    logic signed [KEY_BITS-1:0] table_keys [CAPACITY];
    logic [WORD_BITS-1:0]       table_data [CAPACITY];
    int                         entries;
    int                         cursor_pos;
    logic                       cursor_on;
    table_response_t            response_q [$];
    table_response_t            want;
    int                         response_index;

    initial fail_count = 0;

    task automatic report_mismatch(input string what, input logic [WORD_BITS-1:0] got,
                                   input logic [WORD_BITS-1:0] exp_val);
        $display("ERROR: response %0d %s: got 0x%0h, expected 0x%0h",
                 response_index, what, got, exp_val);
        fail_count++;
    endtask

    // Applies one request to the shadow table and returns the response it should give
    function automatic table_response_t table_step(input logic [OP_BITS-1:0] op,
                                                   input logic signed [KEY_BITS-1:0] key,
                                                   input logic [WORD_BITS-1:0] datum);
        table_response_t        r;
        logic [STATUS_BITS-1:0] st;
        logic [WORD_BITS-1:0]   word;
        logic                   hit;
        int                     pos;
        int                     i;
        r    = '0;
        st   = ST_OK;
        word = datum & DATUM_MASK;
        pos  = 0;
        while (pos < entries && table_keys[pos] < key)
            pos++;
        hit = (pos < entries) && (table_keys[pos] == key);
        case (op)
            OP_INSERT:
            begin
                if (hit)
                    table_data[pos] = word;
                else if (entries >= CAPACITY)
                    st = ST_FULL;
                else
                begin
                    for (i = entries; i > pos; i--)
                    begin
                        table_keys[i] = table_keys[i-1];
                        table_data[i] = table_data[i-1];
                    end
                    table_keys[pos] = key;
                    table_data[pos] = word;
                    entries++;
                end
                cursor_on = 1'b0;
            end
            OP_REMOVE:
            begin
                if (hit)
                begin
                    for (i = pos; i + 1 < entries; i++)
                    begin
                        table_keys[i] = table_keys[i+1];
                        table_data[i] = table_data[i+1];
                    end
                    entries--;
                    if (cursor_on)
                    begin
                        if (cursor_pos == pos)
                            cursor_on = 1'b0;
                        else if (cursor_pos > pos)
                            cursor_pos--;
                    end
                end
                else
                    st = ST_NOT_FOUND;
            end
            OP_FIND:
            begin
                if (hit)
                begin
                    cursor_pos = pos;
                    cursor_on  = 1'b1;
                end
                else
                begin
                    cursor_on = 1'b0;
                    st        = ST_NOT_FOUND;
                end
            end
            OP_FIRST:
            begin
                cursor_pos = 0;
                cursor_on  = (entries > 0);
            end
            OP_STEP:
            begin
                if (!cursor_on)
                    st = ST_CURSOR_BAD;
                else if (cursor_pos + 1 < entries)
                    cursor_pos++;
                else
                    cursor_on = 1'b0;
            end
            OP_CLEAR:
            begin
                entries   = 0;
                cursor_on = 1'b0;
            end
            default:
            begin
            end
        endcase
        if (cursor_on && cursor_pos >= entries)
            cursor_on = 1'b0;
        r.status       = st;
        r.cursor_valid = cursor_on;
        if (cursor_on)
        begin
            r.cur_key   = table_keys[cursor_pos];
            r.cur_datum = table_data[cursor_pos] & DATUM_MASK;
        end
        r.entry_count = COUNT_OUT_BITS'(entries);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries        = 0;
            cursor_pos     = 0;
            cursor_on      = 1'b0;
            response_index = 0;
            response_q.delete();
            pending <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (response_q.size() == 0)
                    report_mismatch("arrived with no request outstanding",
                                    WORD_BITS'(rsp.status), '0);
                else
                begin
                    want = response_q.pop_front();
                    if (rsp.status !== want.status)
                        report_mismatch("status", WORD_BITS'(rsp.status),
                                        WORD_BITS'(want.status));
                    if (rsp.cursor_valid !== want.cursor_valid)
                        report_mismatch("cursor_valid", WORD_BITS'(rsp.cursor_valid),
                                        WORD_BITS'(want.cursor_valid));
                    if (rsp.cur_key !== want.cur_key)
                        report_mismatch("cur_key", WORD_BITS'(rsp.cur_key),
                                        WORD_BITS'(want.cur_key));
                    if (rsp.cur_datum !== want.cur_datum)
                        report_mismatch("cur_datum", rsp.cur_datum, want.cur_datum);
                    if (rsp.entry_count !== want.entry_count)
                        report_mismatch("entry_count", WORD_BITS'(rsp.entry_count),
                                        WORD_BITS'(want.entry_count));
                end
                response_index++;
            end
            if (req.valid && req.ready)
                response_q.push_back(table_step(req.operation, req.key, req.datum));
            pending <= response_q.size();
        end
    end

endmodule

// File: verif/testbench.sv
// Testbench top of the sorted key/datum table: clock, reset, request traffic and verdict.
`timescale 1ns / 100ps
module testbench;
    import skvt_pkg::*;

    typedef enum int {MODE_FILL, MODE_WALK, MODE_CHURN, MODE_NOISE} traffic_mode_t;

    localparam logic [OP_BITS-1:0]         OP_SPARE_A      = 3'd6;
    localparam logic [OP_BITS-1:0]         OP_SPARE_B      = 3'd7;
    localparam logic signed [KEY_BITS-1:0] KEY_MIN         = 32'sh8000_0000;
    localparam logic signed [KEY_BITS-1:0] KEY_MAX         = 32'sh7fff_ffff;
    localparam int                         RANDOM_REQUESTS = 600;
    localparam int                         WATCHDOG_LIMIT  = 4000;
    localparam int                         DRAIN_CYCLES    = 20;
    localparam int                         POOL_DEPTH      = 32;

    logic                       clk   = 1'b0;
    logic                       rst_n = 1'b0;
    int                         fail_count;
    int                         pending;
    int                         burst_left   = 0;
    int                         quiet_cycles = 0;
    logic signed [KEY_BITS-1:0] key_pool [POOL_DEPTH];
    int                         pool_fill = 0;
    int                         pool_next = 0;
    logic [31:0]                ready_pattern;
    int                         pattern_age = 0;

    skvt_req_if req_ch ();
    skvt_rsp_if rsp_ch ();

    sorted_key_value_table_core u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    skvt_table_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Receiver back-pressure: fresh 32-bit patterns, open, mixed or mostly stalled
    always @(negedge clk)
    begin
        if (pattern_age == 0)
        begin
            case ($urandom_range(0, 2))
                0:       ready_pattern = '1;
                1:       ready_pattern = $urandom;
                default: ready_pattern = $urandom & $urandom;
            endcase
            pattern_age = 32;
        end
        rsp_ch.ready <= ready_pattern[0];
        ready_pattern = {ready_pattern[0], ready_pattern[31:1]};
        pattern_age--;
    end

    function automatic logic signed [KEY_BITS-1:0] pick_key();
        logic signed [KEY_BITS-1:0] k;
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 4))
                    0:       k = KEY_MIN;
                    1:       k = KEY_MAX;
                    2:       k = '0;
                    3:       k = -32'sd1;
                    default: k = 32'sd1;
                endcase
            end
            1, 2, 3: k = $urandom;
            default: k = (pool_fill > 0) ? key_pool[$urandom_range(0, pool_fill - 1)] : $urandom;
        endcase
        return k;
    endfunction

    function automatic logic [WORD_BITS-1:0] pick_datum();
        logic [WORD_BITS-1:0] d;
        case ($urandom_range(0, 9))
            0:       d = '0;
            1:       d = '1;
            default: d = {$urandom, $urandom};
        endcase
        return d;
    endfunction

    // Entered and left at a falling edge; a gap may open between bursts
    task automatic send_request(input logic [OP_BITS-1:0] op,
                                input logic signed [KEY_BITS-1:0] key,
                                input logic [WORD_BITS-1:0] datum);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.key       <= key;
        req_ch.datum     <= datum;
        do
            @(posedge clk);
        while (!req_ch.ready);
        @(negedge clk);
        if (op == OP_INSERT)
        begin
            key_pool[pool_next] = key;
            pool_next = (pool_next + 1) % POOL_DEPTH;
            if (pool_fill < POOL_DEPTH)
                pool_fill++;
        end
    endtask

    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        traffic_mode_t              mode;
        logic [OP_BITS-1:0]         op;
        logic signed [KEY_BITS-1:0] key;
        int                         seg_len;
        int                         seg;
        int                         sent;
        int                         roll;
        int                         i;
        req_ch.valid     = 1'b0;
        req_ch.operation = OP_INSERT;
        req_ch.key       = '0;
        req_ch.datum     = '0;
        rsp_ch.ready     = 1'b0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // directed: empty table, extremes, overwrite, cursor moves around removals, spare opcodes, clear
        send_request(OP_STEP,    '0,       '0);
        send_request(OP_FIRST,   '0,       '0);
        send_request(OP_FIND,    32'sd5,   '0);
        send_request(OP_REMOVE,  32'sd5,   '0);
        send_request(OP_INSERT,  KEY_MAX,  '1);
        send_request(OP_INSERT,  KEY_MIN,  '0);
        send_request(OP_INSERT,  '0,       64'h0123_4567_89ab_cdef);
        send_request(OP_INSERT,  '0,       64'hfedc_ba98_7654_3210);
        send_request(OP_INSERT,  -32'sd1,  64'h5555_5555_aaaa_aaaa);
        send_request(OP_FIND,    '0,       '0);
        send_request(OP_INSERT,  32'sd1,   64'h8000_0000_0000_0001);
        send_request(OP_STEP,    '0,       '0);
        send_request(OP_FIRST,   '0,       '0);
        send_request(OP_STEP,    '0,       '0);
        send_request(OP_REMOVE,  KEY_MIN,  '0);
        send_request(OP_STEP,    '0,       '0);
        send_request(OP_REMOVE,  '0,       '0);
        send_request(OP_FIND,    KEY_MAX,  '0);
        send_request(OP_STEP,    '0,       '0);
        send_request(OP_FIND,    32'sd7,   '0);
        send_request(OP_SPARE_A, KEY_MAX,  '1);
        send_request(OP_SPARE_B, KEY_MIN,  '1);
        send_request(OP_CLEAR,   '0,       '0);
        send_request(OP_FIRST,   '0,       '0);

        // random: segments of fill, cursor walks, churn and noise
        sent = 0;
        seg  = 0;
        while (sent < RANDOM_REQUESTS)
        begin
            mode    = (seg == 0) ? MODE_FILL : traffic_mode_t'($urandom_range(0, 3));
            seg_len = (mode == MODE_FILL) ? $urandom_range(75, 95) : $urandom_range(15, 50);
            if (mode == MODE_WALK)
            begin
                send_request(OP_FIRST, pick_key(), pick_datum());
                sent++;
            end
            for (i = 0; i < seg_len; i++)
            begin
                roll = $urandom_range(0, 99);
                case (mode)
                    MODE_FILL:
                        op = (roll < 85) ? OP_INSERT : OP_FIND;
                    MODE_WALK:
                        op = (roll < 80) ? OP_STEP : ((roll < 90) ? OP_FIND : OP_REMOVE);
                    MODE_CHURN:
                    begin
                        if (roll < 35)
                            op = OP_INSERT;
                        else if (roll < 60)
                            op = OP_REMOVE;
                        else if (roll < 80)
                            op = OP_FIND;
                        else if (roll < 90)
                            op = OP_FIRST;
                        else if (roll < 98)
                            op = OP_STEP;
                        else
                            op = OP_CLEAR;
                    end
                    default:
                        op = OP_BITS'($urandom_range(0, 7));
                endcase
                key = (mode == MODE_FILL && op == OP_INSERT) ? $urandom : pick_key();
                send_request(op, key, pick_datum());
                sent++;
            end
            seg++;
        end
        req_ch.valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
